[src/a64rel_pkg.sv]
package a64rel_pkg;

  // default address width of the code buffer arithmetic
  localparam int unsigned ADDR_WIDTH_DEF = 64;

  // field widths of one relocation request and its result
  localparam int unsigned OP_W     = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // input tdata layout, lowest bit first
  localparam int unsigned IN_SITE_LSB   = 0;
  localparam int unsigned IN_TARGET_LSB = IN_SITE_LSB + ADDR_W;
  localparam int unsigned IN_WORD_LSB   = IN_TARGET_LSB + ADDR_W;
  localparam int unsigned IN_TDATA_W    = IN_WORD_LSB + WORD_W;

  // input tuser layout, lowest bit first
  localparam int unsigned IN_OP_LSB   = 0;
  localparam int unsigned IN_KIND_LSB = IN_OP_LSB + OP_W;
  localparam int unsigned IN_TUSER_W  = IN_KIND_LSB + KIND_W;

  // result tdata and tuser layout
  localparam int unsigned OUT_TDATA_W    = ADDR_W;
  localparam int unsigned OUT_WIDE_BIT   = 0;
  localparam int unsigned OUT_STATUS_LSB = 1;
  localparam int unsigned OUT_TUSER_W    = OUT_STATUS_LSB + STATUS_W;

  // relocation kinds
  typedef enum logic [OP_W-1:0] {
    OP_ABS64   = 3'd0,
    OP_REL26   = 3'd1,
    OP_REL19   = 3'd2,
    OP_REL21   = 3'd3,
    OP_PGREL21 = 3'd4,
    OP_REL14   = 3'd5,
    OP_PGOFF12 = 3'd6
  } reloc_op_t;

  // symbol kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_UNDEF    = 2'd0,
    KIND_INTERNAL = 2'd1,
    KIND_EXTERNAL = 2'd2
  } sym_kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_RANGE = 2'd2
  } reloc_status_t;

endpackage

[src/arm64_branch_relocation_patcher_unit.sv]
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | tdata: site_offset, target_value, site_word
//         |     |                        | tuser: operation, target_kind
// out_    | out | out_tvalid / out_tready| tdata: patched_value
//         |     |                        | tuser: wide_write, status
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: code_base
//
// Two register stages: a request enters the input register, where the site and
// target addresses are resolved, and then moves on to the result register.
// One request per cycle is sustained while out_tready does not stall; the two
// address adds and the displacement subtract set the stage delay.
// rst_n is synchronous and active low; it empties both stages and clears code_base.
// A stalled out_tready holds the result; in_tready stays high while either stage
// can move on.
module arm64_branch_relocation_patcher_unit #(
  parameter int unsigned ADDR_WIDTH = a64rel_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transfer
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // site_offset [63:0], target_value [127:64], site_word [159:128]
  input  logic [a64rel_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation [2:0], target_kind [4:3]
  input  logic [a64rel_pkg::IN_TUSER_W-1:0]    in_tuser,
  // result transfer
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // patched_value [63:0]
  output logic [a64rel_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // wide_write [0], status [2:1]
  output logic [a64rel_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // code base write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [a64rel_pkg::ADDR_W-1:0]        cfg_data
);
  import a64rel_pkg::*;

  localparam int unsigned AW  = ADDR_WIDTH;
  localparam int unsigned PGW = AW - 11;

  logic [AW-1:0]       code_base_r;

  logic                s1_valid_r;
  reloc_op_t           s1_op_r;
  sym_kind_t           s1_kind_r;
  logic [AW-1:0]       s1_site_r;
  logic [AW-1:0]       s1_target_r;
  logic [WORD_W-1:0]   s1_word_r;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_value_r;
  logic                out_wide_r;
  reloc_status_t       out_status_r;

  logic                s2_free;
  logic                s1_move;
  logic                in_xfer;

  logic [AW-1:0]       in_site;
  logic [AW-1:0]       in_target;
  sym_kind_t           in_kind;

  logic [AW-1:0]       disp;
  logic [PGW-1:0]      pdisp;
  logic                aligned;
  logic                fit26;
  logic                fit19;
  logic                fit14;
  logic                pfit19;

  logic [ADDR_W-1:0]   value_nxt;
  logic                wide_nxt;
  reloc_status_t       status_nxt;
  logic [WORD_W-1:0]   word_nxt;

  // handshake between the stages
  assign cfg_ready = 1'b1;
  assign s2_free   = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_xfer   = in_tvalid && in_tready;

  // code base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      code_base_r <= cfg_data[AW-1:0];
    end
  end

  // resolve site and target addresses on entry
  assign in_kind = sym_kind_t'(in_tuser[IN_KIND_LSB +: KIND_W]);
  assign in_site = code_base_r + in_tdata[IN_SITE_LSB +: AW];

  always_comb begin
    case (in_kind)
      KIND_INTERNAL: in_target = code_base_r + in_tdata[IN_TARGET_LSB +: AW];
      KIND_EXTERNAL: in_target = in_tdata[IN_TARGET_LSB +: AW];
      default:       in_target = '0;
    endcase
  end

  // input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= reloc_op_t'(in_tuser[IN_OP_LSB +: OP_W]);
      s1_kind_r   <= in_kind;
      s1_site_r   <= in_site;
      s1_target_r <= in_target;
      s1_word_r   <= in_tdata[IN_WORD_LSB +: WORD_W];
    end
  end

  // byte and page displacements with their range checks
  assign disp    = s1_target_r - s1_site_r;
  assign pdisp   = {1'b0, s1_target_r[AW-1:12]} - {1'b0, s1_site_r[AW-1:12]};
  assign aligned = (disp[1:0] == 2'b00);
  assign fit26   = (disp[AW-1:27] == '0) || (disp[AW-1:27] == '1);
  assign fit19   = (disp[AW-1:20] == '0) || (disp[AW-1:20] == '1);
  assign fit14   = (disp[AW-1:15] == '0) || (disp[AW-1:15] == '1);
  assign pfit19  = (pdisp[PGW-1:20] == '0) || (pdisp[PGW-1:20] == '1);

  // encode the immediate into the site word
  always_comb begin
    wide_nxt   = 1'b0;
    status_nxt = ST_OK;
    word_nxt   = s1_word_r;
    if (s1_kind_r != KIND_INTERNAL && s1_kind_r != KIND_EXTERNAL) begin
      status_nxt = ST_UNDEF;
    end else begin
      case (s1_op_r)
        OP_ABS64: begin
          wide_nxt = 1'b1;
        end
        OP_REL26: begin
          if (!aligned || !fit26) status_nxt = ST_RANGE;
          else word_nxt = s1_word_r | {6'b0, disp[27:2]};
        end
        OP_REL19: begin
          if (!aligned || !fit19) status_nxt = ST_RANGE;
          else word_nxt = s1_word_r | {8'b0, disp[20:2], 5'b0};
        end
        OP_REL21: begin
          if (!fit19) status_nxt = ST_RANGE;
          else word_nxt = s1_word_r | {1'b0, disp[1:0], 5'b0, disp[20:2], 5'b0};
        end
        OP_PGREL21: begin
          if (!pfit19) status_nxt = ST_RANGE;
          else word_nxt = s1_word_r | {1'b0, pdisp[1:0], 5'b0, pdisp[20:2], 5'b0};
        end
        OP_REL14: begin
          if (!aligned || !fit14) status_nxt = ST_RANGE;
          else word_nxt = s1_word_r | {13'b0, disp[15:2], 5'b0};
        end
        OP_PGOFF12: begin
          word_nxt = s1_word_r | {10'b0, s1_target_r[11:0], 10'b0};
        end
        default: begin
          word_nxt = s1_word_r;
        end
      endcase
    end
  end

  // select the written value
  always_comb begin
    if (status_nxt != ST_OK) begin
      value_nxt = ADDR_W'(s1_word_r);
    end else if (wide_nxt) begin
      value_nxt = ADDR_W'(s1_target_r);
    end else begin
      value_nxt = ADDR_W'(word_nxt);
    end
  end

  // result register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_value_r  <= value_nxt;
      out_wide_r   <= wide_nxt && (status_nxt == ST_OK);
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_status_r, out_wide_r};

endmodule

[src/a64rel_checker.sv]
module a64rel_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [a64rel_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [a64rel_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import a64rel_pkg::*;

  logic          wide;
  reloc_status_t status;

  assign wide   = out_tuser[OUT_WIDE_BIT];
  assign status = reloc_status_t'(out_tuser[OUT_STATUS_LSB +: STATUS_W]);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a wide write only comes with a good status
  a_wide_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && wide |-> status == ST_OK)
    else $error("wide write with error status");

  // a narrow write carries a 32-bit word only
  a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !wide |-> out_tdata[63:32] == 32'h0)
    else $error("narrow write has upper bits set");

  // the reserved status code never appears
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> status == ST_OK || status == ST_UNDEF || status == ST_RANGE)
    else $error("reserved status code");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind arm64_branch_relocation_patcher_unit a64rel_checker u_a64rel_checker (.*);

[tb/sv/reloc_result_checker.sv]
module reloc_result_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [a64rel_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [a64rel_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [a64rel_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [a64rel_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [a64rel_pkg::ADDR_W-1:0]      cfg_data,
  output int                                 mismatch_count,
  output int                                 patches_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import a64rel_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] value;
    logic              wide;
    reloc_status_t     status;
  } patch_t;

  patch_t            expected_patches[$];
  logic [ADDR_W-1:0] base_copy;

  // signed field fit of a 64-bit two's complement value
  function automatic bit fits_field(input logic [63:0] v, input int unsigned bits);
    logic [63:0] half;
    half = 64'd1 << (bits - 1);
    return (v + half) < (half << 1);
  endfunction

  // resolve target and site, encode the displacement into the site word
  function automatic patch_t resolve_reloc(input logic [OP_W-1:0] op,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [ADDR_W-1:0] site_off,
                                           input logic [ADDR_W-1:0] tval,
                                           input logic [WORD_W-1:0] word,
                                           input logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] site;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] disp;
    logic [ADDR_W-1:0] q;
    logic [WORD_W-1:0] nw;
    logic              wide;
    reloc_status_t     st;
    patch_t            r;
    site = base + site_off;
    case (kind)
      KIND_INTERNAL: target = base + tval;
      KIND_EXTERNAL: target = tval;
      default:       target = '0;
    endcase
    disp = target - site;
    nw   = word;
    wide = 1'b0;
    st   = ST_OK;
    if (kind != KIND_INTERNAL && kind != KIND_EXTERNAL) begin
      st = ST_UNDEF;
    end else begin
      case (op)
        OP_ABS64: wide = 1'b1;
        OP_REL26: begin
          q = $signed(disp) >>> 2;
          if (disp[1:0] != 2'b00 || !fits_field(q, 26)) st = ST_RANGE;
          else nw = word | {6'b0, q[25:0]};
        end
        OP_REL19: begin
          q = $signed(disp) >>> 2;
          if (disp[1:0] != 2'b00 || !fits_field(q, 19)) st = ST_RANGE;
          else nw = word | {8'b0, q[18:0], 5'b0};
        end
        OP_REL21, OP_PGREL21: begin
          // page form works on 4 KiB page numbers
          if (op == OP_PGREL21) disp = (target >> 12) - (site >> 12);
          q = $signed(disp) >>> 2;
          if (!fits_field(q, 19)) st = ST_RANGE;
          else nw = word | {1'b0, disp[1:0], 29'b0} | {8'b0, q[18:0], 5'b0};
        end
        OP_REL14: begin
          q = $signed(disp) >>> 2;
          if (disp[1:0] != 2'b00 || !fits_field(q, 14)) st = ST_RANGE;
          else nw = word | {13'b0, q[13:0], 5'b0};
        end
        OP_PGOFF12: nw = word | {10'b0, target[11:0], 10'b0};
        default: ;
      endcase
    end
    r.status = st;
    if (st != ST_OK) begin
      r.wide  = 1'b0;
      r.value = {32'b0, word};
    end else if (wide) begin
      r.wide  = 1'b1;
      r.value = target;
    end else begin
      r.wide  = 1'b0;
      r.value = {32'b0, nw};
    end
    return r;
  endfunction

  initial begin
    mismatch_count = 0;
    patches_due    = 0;
    base_copy      = '0;
  end

  // track code base, queue predictions, compare results in order
  always @(posedge clk) begin
    patch_t exp_p;
    logic   got_wide;
    logic [STATUS_W-1:0] got_status;
    if (!rst_n) begin
      base_copy = '0;
    end else begin
      if (cfg_valid && cfg_ready) base_copy = cfg_data;
      if (in_tvalid && in_tready) begin
        expected_patches.push_back(resolve_reloc(
          in_tuser[IN_OP_LSB +: OP_W], in_tuser[IN_KIND_LSB +: KIND_W],
          in_tdata[IN_SITE_LSB +: ADDR_W], in_tdata[IN_TARGET_LSB +: ADDR_W],
          in_tdata[IN_WORD_LSB +: WORD_W], base_copy));
      end
      if (out_tvalid && out_tready) begin
        got_wide   = out_tuser[OUT_WIDE_BIT];
        got_status = out_tuser[OUT_STATUS_LSB +: STATUS_W];
        if (expected_patches.size() == 0) begin
          $display("%0t: result transfer with nothing expected: value %h wide %b status %0d",
                   $time, out_tdata, got_wide, got_status);
          mismatch_count++;
        end else begin
          exp_p = expected_patches.pop_front();
          if (out_tdata !== exp_p.value) begin
            $display("%0t: patched_value expected %h actual %h",
                     $time, exp_p.value, out_tdata);
            mismatch_count++;
          end
          if (got_wide !== exp_p.wide) begin
            $display("%0t: wide_write expected %b actual %b", $time, exp_p.wide, got_wide);
            mismatch_count++;
          end
          if (got_status !== exp_p.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_p.status, got_status);
            mismatch_count++;
          end
        end
      end
    end
    patches_due = expected_patches.size();
  end

endmodule

[tb/sv/arm64_branch_relocation_patcher_unit_tb.sv]
module arm64_branch_relocation_patcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import a64rel_pkg::*;

  localparam logic [OP_W-1:0]   OP_RESERVED   = 3'd7;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASE_ITEMS     = 255;
  localparam int SETTLE_CYCLES   = 4;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [ADDR_W-1:0]      cfg_data;

  int                mismatch_count;
  int                patches_due;
  int                cycle_count;
  logic [ADDR_W-1:0] cur_base;
  bit                in_steady;
  bit                out_steady;

  arm64_branch_relocation_patcher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  reloc_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .patches_due    (patches_due)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run time guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // one relocation transfer; for an internal or external kind the target is placed disp bytes from the site
  task automatic send_reloc(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                            input logic [ADDR_W-1:0] site_off,
                            input logic [ADDR_W-1:0] disp,
                            input logic [WORD_W-1:0] word);
    logic [ADDR_W-1:0] tval;
    int gap;
    case (kind)
      KIND_INTERNAL: tval = site_off + disp;
      KIND_EXTERNAL: tval = cur_base + site_off + disp;
      default:       tval = {$urandom, $urandom};
    endcase
    gap = in_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {word, tval, site_off};
    in_tuser  = {kind, op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_code_base(input logic [ADDR_W-1:0] v);
    in_tvalid = 1'b0;
    while (patches_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_base  = v;
  endtask

  // displacement near the field limits, small, or anywhere
  function automatic logic [ADDR_W-1:0] pick_disp(input logic [OP_W-1:0] op);
    int unsigned bits;
    int unsigned mode;
    logic [ADDR_W-1:0] d;
    case (op)
      OP_REL26:   bits = 27;
      OP_REL14:   bits = 15;
      OP_PGREL21: bits = 32;
      default:    bits = 20;
    endcase
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      d = 64'd1 << bits;
      if ($urandom_range(0, 1)) d = -d;
      if (op == OP_PGREL21) d = d + 64'((int'($urandom_range(0, 8)) - 4) * 4096)
                                  + 64'($urandom_range(0, 4095));
      else d = d + 64'(int'($urandom_range(0, 16)) - 8);
    end else if (mode < 8) begin
      d = {$urandom, $urandom};
      d = $signed(d) >>> (64 - $urandom_range(1, bits + 1));
      if ($urandom_range(0, 3) != 0) d[1:0] = 2'b00;
    end else begin
      d = {$urandom, $urandom};
    end
    return d;
  endfunction

  initial begin
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] site_off;
    logic [ADDR_W-1:0] nb;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    cur_base   = '0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: code base at its reset value
    send_reloc(OP_ABS64, KIND_INTERNAL, '0, '0, 32'hFFFF_FFFF);   // zero target address
    send_reloc(OP_ABS64, KIND_EXTERNAL, '1, '0, 32'h0);
    send_reloc(OP_REL26, KIND_UNDEF, 64'h40, 64'h8, 32'h1400_0000);
    send_reloc(OP_PGOFF12, KIND_RESERVED, 64'h40, 64'h8, 32'h9100_0000);
    send_reloc(OP_RESERVED, KIND_INTERNAL, 64'h100, 64'h100, 32'h1234_5678);
    send_reloc(OP_RESERVED, KIND_UNDEF, 64'h100, 64'h100, 32'h1234_5678);
    send_reloc(OP_REL26, KIND_INTERNAL, 64'h1000, (64'd1 << 27) - 4, 32'h9400_0000);
    send_reloc(OP_REL26, KIND_EXTERNAL, 64'h1000, -(64'd1 << 27), 32'h1400_0000);
    send_reloc(OP_REL26, KIND_INTERNAL, 64'h1000, 64'd1 << 27, 32'h1400_0000);
    send_reloc(OP_REL26, KIND_INTERNAL, 64'h1000, 64'd2, 32'h1400_0000);
    send_reloc(OP_REL19, KIND_INTERNAL, '1, (64'd1 << 20) - 4, 32'h5400_0000);
    send_reloc(OP_REL19, KIND_EXTERNAL, 64'h2000, -(64'd1 << 20) - 4, 32'hB400_0000);
    send_reloc(OP_REL19, KIND_INTERNAL, 64'h2000, 64'd1, 32'h5400_0000);
    send_reloc(OP_REL21, KIND_INTERNAL, 64'h3000, 64'd3, 32'h1000_0000);
    send_reloc(OP_REL21, KIND_EXTERNAL, 64'h3000, -(64'd1 << 20), 32'h1000_0000);
    send_reloc(OP_REL21, KIND_INTERNAL, 64'h3000, 64'd1 << 20, 32'h1000_0000);
    send_reloc(OP_PGREL21, KIND_INTERNAL, 64'hFFF, 64'd1, 32'h9000_0000);
    send_reloc(OP_PGREL21, KIND_EXTERNAL, 64'h0, ((64'd1 << 20) - 1) << 12, 32'h9000_0000);
    send_reloc(OP_PGREL21, KIND_INTERNAL, 64'h0, (64'd1 << 20) << 12, 32'h9000_0000);
    send_reloc(OP_REL14, KIND_INTERNAL, 64'h4000, (64'd1 << 15) - 4, 32'h3600_0000);
    send_reloc(OP_REL14, KIND_EXTERNAL, 64'h4000, -(64'd1 << 15), 32'h3600_0000);
    send_reloc(OP_REL14, KIND_INTERNAL, 64'h4000, -(64'd1 << 15) - 4, 32'h3600_0000);
    send_reloc(OP_PGOFF12, KIND_EXTERNAL, '0, '1, 32'h0);
    send_reloc(OP_ABS64, KIND_UNDEF, 64'h8, 64'h8, 32'hFFFF_FFFF);

    // random phases, each under its own code base
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       nb = '1;
        2:       nb = '0;
        3:       nb = 64'h8000_0000_0000_0000;
        4:       nb = 64'hFFFF_FFFF_FFFF_F000;
        default: nb = {$urandom, $urandom};
      endcase
      write_code_base(nb);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) begin
          in_steady  = ($urandom_range(0, 3) == 0);
          out_steady = ($urandom_range(0, 3) == 0);
        end
        op = ($urandom_range(0, 31) == 0) ? OP_RESERVED : OP_W'($urandom_range(0, 6));
        if ($urandom_range(0, 15) == 0)
          kind = $urandom_range(0, 1) ? KIND_RESERVED : KIND_UNDEF;
        else
          kind = KIND_W'($urandom_range(1, 2));
        site_off = ($urandom_range(0, 3) == 0) ? {32'b0, $urandom} : {$urandom, $urandom};
        send_reloc(op, kind, site_off, pick_disp(op), $urandom);
      end
    end

    // drain and verdict
    in_tvalid  = 1'b0;
    out_steady = 1'b0;
    while (patches_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
